>>> rtl/wsfu_pkg.sv
package wsfu_pkg;

  // Parse phases of the frame decoder
  localparam logic [2:0] PhHdr0    = 3'd0;
  localparam logic [2:0] PhHdr1    = 3'd1;
  localparam logic [2:0] PhExtLen  = 3'd2;
  localparam logic [2:0] PhMask    = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;

  // 7-bit length field and its escape codes
  localparam logic [6:0] Len7Mask = 7'h7F;
  localparam logic [6:0] LenExt16 = 7'd126;
  localparam logic [6:0] LenExt64 = 7'd127;

  // Extended length byte counts and mask key size
  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;
  localparam logic [3:0] KeyBytes   = 4'd4;

endpackage

>>> rtl/websocket_frame_unmasker.sv
// Byte-serial decoder for masked client WebSocket frames.
//
// Input channel (in_valid_i / in_ready_o / in_byte_i): one raw frame byte per
// beat. The two base header bytes, the optional 16- or 64-bit big-endian
// extended length and the four mask-key bytes are absorbed without output.
// Every payload byte leaves on the output channel (out_valid_o / out_ready_i)
// as payload_byte_o = in_byte XOR key byte (position mod 4), with
// last_of_frame_o set on the final payload byte of the frame.
//
// Throughput: one input beat per clock while the skid register is empty. The
// decode is a single short combinational step from the parse registers into
// the output register, which takes each accepted payload byte unless it still
// holds a beat that the receiver has not taken.
// Stall: an output register plus a one-entry skid register sit between the
// decoder and the receiver; in_ready_o drops only while the skid register
// holds a beat, so header bytes keep flowing while one result waits.
// Reset (rst_ni low, asynchronous): the decoder expects the first header byte,
// and both output stages are emptied.
module websocket_frame_unmasker
  import wsfu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] payload_byte_o,
  output logic       last_of_frame_o
);

  // Parse state
  logic [2:0]  phase_q, phase_d;
  logic [3:0]  hdr_cnt_q, hdr_cnt_d;
  logic [63:0] remain_q, remain_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  mask_pos_q, mask_pos_d;

  // Output and skid stages
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       skid_valid_q;
  logic [7:0] skid_byte_q;
  logic       skid_last_q;

  logic        accept;
  logic        res_valid;
  logic [7:0]  res_byte;
  logic        res_last;
  logic [6:0]  len7;
  logic [63:0] remain_dec;
  logic [7:0]  key_byte;
  logic [3:0]  key_cnt_inc;
  logic        pop;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;

  assign len7        = in_byte_i[6:0] & Len7Mask;
  assign remain_dec  = remain_q - 64'd1;
  assign key_cnt_inc = hdr_cnt_q + 4'd1;

  // Select key byte: position 0 is the first key byte, held in the top bits
  always_comb begin
    case (mask_pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Decode one byte
  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    remain_d   = remain_q;
    key_d      = key_q;
    mask_pos_d = mask_pos_q;
    res_valid  = 1'b0;
    res_byte   = in_byte_i ^ key_byte;
    res_last   = (remain_dec == 64'd0);
    case (phase_q)
      PhHdr1: begin
        remain_d   = '0;
        key_d      = '0;
        mask_pos_d = '0;
        if (len7 == LenExt16) begin
          hdr_cnt_d = ExtBytes16;
          phase_d   = PhExtLen;
        end else if (len7 == LenExt64) begin
          hdr_cnt_d = ExtBytes64;
          phase_d   = PhExtLen;
        end else begin
          remain_d  = {57'd0, len7};
          hdr_cnt_d = '0;
          phase_d   = PhMask;
        end
      end
      PhExtLen: begin
        remain_d  = {remain_q[55:0], in_byte_i};
        hdr_cnt_d = hdr_cnt_q - 4'd1;
        if (hdr_cnt_d == 4'd0) begin
          phase_d = PhMask;
        end
      end
      PhMask: begin
        key_d     = {key_q[23:0], in_byte_i};
        hdr_cnt_d = key_cnt_inc;
        if (key_cnt_inc >= KeyBytes) begin
          hdr_cnt_d  = '0;
          mask_pos_d = '0;
          phase_d    = (remain_q == 64'd0) ? PhHdr0 : PhPayload;
        end
      end
      PhPayload: begin
        res_valid  = 1'b1;
        remain_d   = remain_dec;
        mask_pos_d = mask_pos_q + 2'd1;
        if (res_last) begin
          phase_d    = PhHdr0;
          mask_pos_d = '0;
        end
      end
      default: begin
        // First header byte, and any unused phase code: drop the byte
        phase_d   = PhHdr1;
        hdr_cnt_d = '0;
      end
    endcase
  end

  // Advance parse state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHdr0;
      hdr_cnt_q  <= '0;
      remain_q   <= '0;
      key_q      <= '0;
      mask_pos_q <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      remain_q   <= remain_d;
      key_q      <= key_d;
      mask_pos_q <= mask_pos_d;
    end
  end

  // Output register with skid stage: the skid fills only when the output
  // register holds a beat that the receiver does not take this cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_q <= accept && res_valid;
    end else if (accept && res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_byte_q <= skid_byte_q;
        out_last_q <= skid_last_q;
      end
    end else if (!out_valid_q || pop) begin
      out_byte_q <= res_byte;
      out_last_q <= res_last;
    end else begin
      skid_byte_q <= res_byte;
      skid_last_q <= res_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = out_byte_q;
  assign last_of_frame_o = out_last_q;

  // The skid stage never holds a beat ahead of an empty output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  // In the extended length phase between one and eight bytes are still due
  a_extlen_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhExtLen) |-> (hdr_cnt_q != 4'd0 && hdr_cnt_q <= ExtBytes64))
    else $error("extended length byte count out of range");

  // The final payload byte returns the decoder to the first header byte
  a_last_to_hdr0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_q == PhPayload && remain_q == 64'd1) |=> (phase_q == PhHdr0))
    else $error("decoder did not return to header after last payload byte");

  // A payload phase always has bytes left to deliver
  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPayload) |-> (remain_q != 64'd0))
    else $error("payload phase with nothing remaining");

endmodule
